@@ rtl/ostt_pkg.sv @@
// Shared types and constants for the one-shot timer slot table.
// No dependencies; used by ostt_alu, the top module and the checker.
package ostt_pkg;

  localparam int ID_W    = 32;
  localparam int DLY_W   = 32;
  localparam int TIME_W  = 63;
  localparam int DUE_W   = 64;
  localparam int PROD_W  = 42;  // 32-bit delay times 1000 fits in 42 bits
  localparam int ENTRY_W = ID_W + DUE_W;

  localparam logic [9:0] US_PER_MS = 10'd1000;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // most fire results one tick can give
  localparam int MAX_RESULTS = 8;
  localparam int RES_IW      = $clog2(MAX_RESULTS);
  localparam int RES_CW      = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] OP_SCHEDULE   = 2'd0;
  localparam logic [1:0] OP_CANCEL     = 2'd1;
  localparam logic [1:0] OP_CANCEL_ALL = 2'd2;
  localparam logic [1:0] OP_TICK       = 2'd3;

  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_ZERO_ID = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_FIRED   = 3'd3;
  localparam logic [2:0] ST_NONE    = 3'd4;

  typedef enum logic {
    CMP_DUE,  // slot due at or before now
    CMP_MIN   // slot due earlier than running minimum
  } cmp_mode_t;

endpackage

@@ rtl/ostt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ostt_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/ostt_alu.sv @@
// Shared 64-bit magnitude compare used by both slot scans.
// Depends on ostt_pkg.
module ostt_alu (
  input  ostt_pkg::cmp_mode_t               mode,
  input  logic [ostt_pkg::DUE_W-1:0]        slot_due,
  input  logic [ostt_pkg::TIME_W-1:0]       now,
  input  logic [ostt_pkg::DUE_W-1:0]        min_due,
  output logic                              hit
);

  logic [ostt_pkg::DUE_W-1:0] x;
  logic [ostt_pkg::DUE_W-1:0] y;
  logic                       lt;

  always_comb begin
    unique case (mode)
      ostt_pkg::CMP_DUE: begin
        x = {1'b0, now};
        y = slot_due;
      end
      ostt_pkg::CMP_MIN: begin
        x = slot_due;
        y = min_due;
      end
      default: begin
        x = slot_due;
        y = min_due;
      end
    endcase
    lt  = x < y;
    // due <= now is the complement of now < due
    hit = (mode == ostt_pkg::CMP_DUE) ? !lt : lt;
  end

endmodule

@@ rtl/one_shot_timer_slot_table.sv @@
// One-shot timer slot table.
//
// Input channel (in_valid/in_ready) takes one command beat: op, timer_id,
// delay, now_us. Output channel (out_valid/out_ready) gives result beats:
// status, fired_id, next_due, last. A command gives one beat; a tick gives
// one beat per fired slot (up to eight, last marked) or one "nothing due".
//
// Per item the sequencer walks the slot RAM through a single read port and
// one shared comparator, one slot per cycle: a match/fire pass, an optional
// write of the scheduled slot, then an earliest-due pass. Cancel-all and a
// zero id skip the first pass and the write. in_ready is high only between
// items, from the cycle after the last beat is loaded.
//
// Reset clears all active flags and the output valid; slot ids and due times
// are left as they are and only read once written. A stalled receiver holds
// the output register; the block waits with the pending beat and takes no
// new item until its results are all loaded.
// Depends on ostt_pkg, ostt_ram, ostt_alu.
module one_shot_timer_slot_table #(
  parameter int SLOTS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      op,
  input  logic [ostt_pkg::ID_W-1:0]       timer_id,
  input  logic [ostt_pkg::DLY_W-1:0]      delay,
  input  logic [ostt_pkg::TIME_W-1:0]     now_us,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      status,
  output logic [ostt_pkg::ID_W-1:0]       fired_id,
  output logic [ostt_pkg::TIME_W-1:0]     next_due,
  output logic                            last
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_A,
    S_WRITE,
    S_SCAN_B,
    S_EMIT
  } state_t;

  state_t state;

  logic [1:0]                      op_q;
  logic [ostt_pkg::ID_W-1:0]       id_q;
  logic [ostt_pkg::DLY_W-1:0]      dly_q;
  logic [ostt_pkg::TIME_W-1:0]     now_q;
  logic [2:0]                      st_q;
  logic [ostt_pkg::PROD_W-1:0]     prod;
  logic [ostt_pkg::DUE_W-1:0]      due_new;

  logic [SLOTS-1:0]                active;
  logic [CW-1:0]                   cnt;
  logic                            pvld;
  logic [IW-1:0]                   pidx;
  logic                            hit;
  logic [IW-1:0]                   hidx;
  logic                            free_ok;
  logic [IW-1:0]                   fidx;
  logic                            min_ok;
  logic [ostt_pkg::DUE_W-1:0]      min_due;
  logic [ostt_pkg::RES_CW-1:0]     nfire;
  logic [ostt_pkg::RES_CW-1:0]     ecnt;
  logic [ostt_pkg::ID_W-1:0]       idbuf [ostt_pkg::MAX_RESULTS];

  logic                            ram_we;
  logic [IW-1:0]                   ram_waddr;
  logic [ostt_pkg::ENTRY_W-1:0]    ram_rdata;
  logic [ostt_pkg::ID_W-1:0]       rd_id;
  logic [ostt_pkg::DUE_W-1:0]      rd_due;
  ostt_pkg::cmp_mode_t             cmp_mode;
  logic                            cmp_hit;
  logic                            scan_end;
  logic [ostt_pkg::TIME_W-1:0]     nd_sat;
  logic                            emit_last;
  logic                            emit_go;

  assign in_ready  = (state == S_IDLE);
  assign rd_id     = ram_rdata[ostt_pkg::ENTRY_W-1 -: ostt_pkg::ID_W];
  assign rd_due    = ram_rdata[ostt_pkg::DUE_W-1:0];
  assign ram_we    = (state == S_WRITE);
  assign ram_waddr = hit ? hidx : fidx;
  assign cmp_mode  = (state == S_SCAN_A) ? ostt_pkg::CMP_DUE : ostt_pkg::CMP_MIN;
  assign scan_end  = (cnt == CW'(SLOTS)) && !pvld;
  assign nd_sat    = !min_ok ? '0 :
                     min_due[ostt_pkg::DUE_W-1] ? ostt_pkg::TIME_MAX :
                     min_due[ostt_pkg::TIME_W-1:0];
  assign emit_last = ((ecnt + ostt_pkg::RES_CW'(1)) == nfire);
  assign emit_go   = (state == S_EMIT) && (!out_valid || out_ready);

  ostt_ram #(
    .WIDTH (ostt_pkg::ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({id_q, due_new}),
    .raddr (cnt[IW-1:0]),
    .rdata (ram_rdata)
  );

  ostt_alu u_alu (
    .mode     (cmp_mode),
    .slot_due (rd_due),
    .now      (now_q),
    .min_due  (min_due),
    .hit      (cmp_hit)
  );

  // due time datapath: multiply, register, then add
  always_ff @(posedge clk) begin
    prod    <= ostt_pkg::PROD_W'(dly_q) * ostt_pkg::PROD_W'(ostt_pkg::US_PER_MS);
    due_new <= {1'b0, now_q} + ostt_pkg::DUE_W'(prod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      active    <= '0;
      out_valid <= 1'b0;
      cnt       <= '0;
      pvld      <= 1'b0;
      hit       <= 1'b0;
      free_ok   <= 1'b0;
      min_ok    <= 1'b0;
      nfire     <= '0;
      ecnt      <= '0;
    end else begin
      if (out_ready && !emit_go) begin
        out_valid <= 1'b0;
      end

      // read issue shared by both scans
      if (state == S_SCAN_A || state == S_SCAN_B) begin
        if (cnt != CW'(SLOTS)) begin
          pidx <= cnt[IW-1:0];
          cnt  <= cnt + CW'(1);
          pvld <= 1'b1;
        end else begin
          pvld <= 1'b0;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q    <= op;
            id_q    <= timer_id;
            dly_q   <= delay;
            now_q   <= now_us;
            st_q    <= ostt_pkg::ST_DONE;
            cnt     <= '0;
            pvld    <= 1'b0;
            hit     <= 1'b0;
            free_ok <= 1'b0;
            min_ok  <= 1'b0;
            nfire   <= '0;
            ecnt    <= '0;
            if (op == ostt_pkg::OP_CANCEL_ALL) begin
              active <= '0;
              state  <= S_SCAN_B;
            end else if (op != ostt_pkg::OP_TICK && timer_id == '0) begin
              st_q  <= ostt_pkg::ST_ZERO_ID;
              state <= S_SCAN_B;
            end else begin
              state <= S_SCAN_A;
            end
          end
        end

        S_SCAN_A: begin
          if (pvld) begin
            case (op_q)
              ostt_pkg::OP_TICK: begin
                if (active[pidx] && cmp_hit &&
                    nfire != ostt_pkg::RES_CW'(ostt_pkg::MAX_RESULTS)) begin
                  active[pidx] <= 1'b0;
                  idbuf[nfire[ostt_pkg::RES_IW-1:0]] <= rd_id;
                  nfire <= nfire + ostt_pkg::RES_CW'(1);
                end
              end
              ostt_pkg::OP_CANCEL: begin
                if (active[pidx] && rd_id == id_q) begin
                  active[pidx] <= 1'b0;
                end
              end
              default: begin
                if (active[pidx] && rd_id == id_q && !hit) begin
                  hit  <= 1'b1;
                  hidx <= pidx;
                end
                if (!active[pidx] && !free_ok) begin
                  free_ok <= 1'b1;
                  fidx    <= pidx;
                end
              end
            endcase
          end
          if (scan_end) begin
            cnt <= '0;
            if (op_q == ostt_pkg::OP_SCHEDULE) begin
              if (hit || free_ok) begin
                state <= S_WRITE;
              end else begin
                st_q  <= ostt_pkg::ST_FULL;
                state <= S_SCAN_B;
              end
            end else begin
              state <= S_SCAN_B;
            end
          end
        end

        S_WRITE: begin
          active[ram_waddr] <= 1'b1;
          cnt               <= '0;
          pvld              <= 1'b0;
          state             <= S_SCAN_B;
        end

        S_SCAN_B: begin
          if (pvld && active[pidx] && (!min_ok || cmp_hit)) begin
            min_due <= rd_due;
            min_ok  <= 1'b1;
          end
          if (scan_end) begin
            state <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (emit_go) begin
            out_valid <= 1'b1;
            next_due  <= nd_sat;
            if (op_q == ostt_pkg::OP_TICK && nfire != '0) begin
              status   <= ostt_pkg::ST_FIRED;
              fired_id <= idbuf[ecnt[ostt_pkg::RES_IW-1:0]];
              last     <= emit_last;
              ecnt     <= ecnt + ostt_pkg::RES_CW'(1);
              if (emit_last) begin
                state <= S_IDLE;
              end
            end else begin
              status   <= (op_q == ostt_pkg::OP_TICK) ? ostt_pkg::ST_NONE : st_q;
              fired_id <= '0;
              last     <= 1'b1;
              state    <= S_IDLE;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/ostt_chk.sv @@
// Port-level checker for the one-shot timer slot table, with its bind.
// Depends on ostt_pkg and one_shot_timer_slot_table.
module ostt_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [2:0]                      status,
  input logic [ostt_pkg::ID_W-1:0]       fired_id,
  input logic [ostt_pkg::TIME_W-1:0]     next_due,
  input logic                            last
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(fired_id) && $stable(next_due) && $stable(last))
    else $error("result beat changed while stalled");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  a_fired_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ostt_pkg::ST_FIRED |-> fired_id == '0)
    else $error("fired_id set on non-fire beat");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ostt_pkg::ST_FIRED |-> last)
    else $error("single-beat result not marked last");

endmodule

bind one_shot_timer_slot_table ostt_chk u_ostt_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status),
  .fired_id  (fired_id),
  .next_due  (next_due),
  .last      (last)
);
